// File: src/ffkc_pkg.sv
// Shared types, key codes and clipping helpers for the keypad calculator.
`default_nettype none
package ffkc_pkg;

	localparam int DATA_W            = 64;
	localparam int MAG_W             = 128;
	localparam int FRACTION_BITS_DEF = 16;

	// Key event codes
	localparam logic [2:0] OP_DIGIT     = 3'd0;
	localparam logic [2:0] OP_OPERATOR  = 3'd1;
	localparam logic [2:0] OP_EQUALS    = 3'd2;
	localparam logic [2:0] OP_CLEAR     = 3'd3;
	localparam logic [2:0] OP_CLEAR_ALL = 3'd4;

	// Arithmetic operator codes
	localparam logic [1:0] OPR_ADD = 2'd0;
	localparam logic [1:0] OPR_SUB = 2'd1;
	localparam logic [1:0] OPR_MUL = 2'd2;
	localparam logic [1:0] OPR_DIV = 2'd3;

	localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [MAG_W-1:0]  mag_t;

	typedef struct packed {
		logic  sat;
		word_t val;
	} clip_t;

	// Request to the iterative multiply/divide unit
	typedef struct packed {
		logic start;
		logic is_div;
	} iter_req_t;

	// Status from the iterative unit
	typedef struct packed {
		logic done;
	} iter_rsp_t;

	// Clip a 65-bit signed sum to the 64-bit range
	function automatic clip_t clip65(input logic [DATA_W:0] s);
		clip_t r;
		if (s[DATA_W] != s[DATA_W-1]) begin
			r.sat = 1'b1;
			r.val = s[DATA_W] ? VAL_MIN : VAL_MAX;
		end else begin
			r.sat = 1'b0;
			r.val = s[DATA_W-1:0];
		end
		return r;
	endfunction

	// Apply a sign to an unsigned magnitude and clip to the 64-bit range
	function automatic clip_t clip_mag(input mag_t m, input logic neg);
		clip_t r;
		logic  hi_zero;
		hi_zero = (m[MAG_W-1:DATA_W] == '0);
		if (neg) begin
			r.sat = !hi_zero || (m[DATA_W-1] && (m[DATA_W-2:0] != '0));
			r.val = r.sat ? VAL_MIN : (word_t'(0) - m[DATA_W-1:0]);
		end else begin
			r.sat = !hi_zero || m[DATA_W-1];
			r.val = r.sat ? VAL_MAX : m[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: src/ffkc_iter_unit.sv
// Bit-serial multiply and restoring divide on one shared 66-bit adder.
`default_nettype none
module ffkc_iter_unit #(
	parameter int FRACTION_BITS = ffkc_pkg::FRACTION_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ffkc_pkg::iter_req_t req,
	input  wire ffkc_pkg::word_t   a_mag,
	input  wire ffkc_pkg::word_t   b_mag,
	output ffkc_pkg::iter_rsp_t    rsp,
	output ffkc_pkg::mag_t         mag
);
	import ffkc_pkg::*;

	localparam int LW    = DATA_W + FRACTION_BITS;
	localparam int CNT_W = $clog2(LW + 1);
	localparam int ADD_W = DATA_W + 2;

	typedef logic [LW-1:0] lw_t;

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             div_q;
	word_t            dvs_q;
	word_t            hi_q;
	lw_t              lo_q;

	logic [ADD_W-1:0] add_x;
	logic [ADD_W-1:0] add_y;
	logic [ADD_W-1:0] add_s;
	logic             ge;
	logic [MAG_W-1:0] prod;

	// Shared adder: add for multiply, subtract for divide
	always_comb begin
		add_x = div_q ? {1'b0, hi_q, lo_q[LW-1]} : {2'b00, hi_q};
		add_y = {2'b00, dvs_q};
		add_s = add_x + (div_q ? ~add_y : add_y) + ADD_W'(div_q);
		ge    = !add_s[ADD_W-1];
	end

	// Step the sequence, one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.is_div ? CNT_W'(LW) : CNT_W'(DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Hold operands and partial results
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			dvs_q <= req.is_div ? b_mag : a_mag;
			hi_q  <= '0;
			lo_q  <= req.is_div ? (lw_t'(a_mag) << FRACTION_BITS) : lw_t'(b_mag);
		end else if (busy_q) begin
			if (div_q) begin
				hi_q <= ge ? add_s[DATA_W-1:0] : add_x[DATA_W-1:0];
				lo_q <= {lo_q[LW-2:0], ge};
			end else if (lo_q[0]) begin
				hi_q <= add_s[DATA_W:1];
				lo_q <= {add_s[0], lo_q[LW-1:1]};
			end else begin
				hi_q <= {1'b0, hi_q[DATA_W-1:1]};
				lo_q <= {hi_q[0], lo_q[LW-1:1]};
			end
		end
	end

	// Select the finished magnitude
	always_comb begin
		prod     = {hi_q, lo_q[LW-1 -: DATA_W]};
		mag      = div_q ? MAG_W'(lo_q) : (prod >> FRACTION_BITS);
		rsp.done = done_q;
	end

endmodule
`default_nettype wire

// File: src/four_function_keypad_calculator_top.sv
// Top level of the keypad calculator: key decode, operand state and sequencer.
//
//  channel  direction  handshake            payload
//  in       receive    in_valid / in_stall  operation, digit, operator_code
//  out      send       out_valid / out_stall display_value .. saturated
//
// Digit, add, subtract, clear and other keys finish in the cycle they are taken.
// Multiply and divide are launched to the iterative unit, which retires one
// product or quotient bit per cycle on its adder; the result is committed in ST_FIN.
// Reset clears all operands, the operator and the output valid.
// A result is held in the output register until taken; in_stall stays high
// while a multiply or divide runs or while a result waits under out_stall.
`default_nettype none
module four_function_keypad_calculator_top #(
	parameter int FRACTION_BITS = ffkc_pkg::FRACTION_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  operation,
	input  wire logic [3:0]  digit,
	input  wire logic [1:0]  operator_code,
	output logic             out_valid,
	input  wire logic        out_stall,
	output ffkc_pkg::word_t  display_value,
	output ffkc_pkg::word_t  first_value,
	output ffkc_pkg::word_t  second_value,
	output logic [1:0]       chosen_operator,
	output logic             operator_valid,
	output logic             divide_by_zero,
	output logic             saturated
);
	import ffkc_pkg::*;

	localparam int EXT_W = DATA_W + 8;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t     st_q, st_d;
	word_t      first_q, second_q, shown_q;
	logic       pressed_q, present_q;
	logic [1:0] held_q;
	logic       dz_q, sat_q, out_valid_q;
	logic       pend_q, neg_q;
	logic [1:0] code_q;

	word_t      nx_first, nx_second, nx_shown;
	logic       nx_pressed, nx_present, nx_dz, nx_sat;
	logic [1:0] nx_held;
	logic       commit, launch, do_eval, in_take;

	logic [EXT_W-1:0]  tgt_ext, dig_sum;
	logic [DATA_W:0]   add_s, sub_s;
	clip_t             add_c, sub_c, fin_c;
	clip_t             dig_c;
	word_t             tgt, mag_a, mag_b;

	iter_req_t req;
	iter_rsp_t rsp;
	mag_t      mag;

	ffkc_iter_unit #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.a_mag  (mag_a),
		.b_mag  (mag_b),
		.rsp    (rsp),
		.mag    (mag)
	);

	assign in_stall = (st_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_take  = in_valid && !in_stall;

	// Build the clipped key results and the magnitudes for the iterative unit
	always_comb begin
		tgt     = pressed_q ? second_q : first_q;
		tgt_ext = {{(EXT_W-DATA_W){tgt[DATA_W-1]}}, tgt};
		dig_sum = (tgt_ext << 3) + (tgt_ext << 1) + (EXT_W'(digit) << FRACTION_BITS);
		if (dig_sum[EXT_W-1:DATA_W-1] == '0 || dig_sum[EXT_W-1:DATA_W-1] == '1) begin
			dig_c.sat = 1'b0;
			dig_c.val = dig_sum[DATA_W-1:0];
		end else begin
			dig_c.sat = 1'b1;
			dig_c.val = dig_sum[EXT_W-1] ? VAL_MIN : VAL_MAX;
		end
		add_s = {first_q[DATA_W-1], first_q} + {second_q[DATA_W-1], second_q};
		sub_s = {first_q[DATA_W-1], first_q} - {second_q[DATA_W-1], second_q};
		add_c = clip65(add_s);
		sub_c = clip65(sub_s);
		mag_a = first_q[DATA_W-1] ? (word_t'(0) - first_q) : first_q;
		mag_b = second_q[DATA_W-1] ? (word_t'(0) - second_q) : second_q;
		fin_c = clip_mag(mag, neg_q);
	end

	// Decode the key request and work out the next state
	always_comb begin
		nx_first   = first_q;
		nx_second  = second_q;
		nx_shown   = shown_q;
		nx_pressed = pressed_q;
		nx_present = present_q;
		nx_held    = held_q;
		nx_dz      = 1'b0;
		nx_sat     = 1'b0;
		commit     = 1'b0;
		launch     = 1'b0;
		do_eval    = 1'b0;
		st_d       = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_take) begin
					commit  = 1'b1;
					do_eval = pressed_q && ((operation == OP_EQUALS) ||
						(operation == OP_OPERATOR && second_q != '0));
					case (operation)
						OP_DIGIT: begin
							if (pressed_q) begin
								nx_second = dig_c.val;
							end else begin
								nx_first = dig_c.val;
							end
							nx_shown = dig_c.val;
							nx_sat   = dig_c.sat;
						end
						OP_CLEAR, OP_CLEAR_ALL: begin
							nx_first   = '0;
							nx_second  = '0;
							nx_shown   = '0;
							nx_pressed = 1'b0;
							if (operation == OP_CLEAR_ALL) begin
								nx_held    = OPR_ADD;
								nx_present = 1'b0;
							end
						end
						default: begin
						end
					endcase
					// Evaluate the pending operation
					if (do_eval) begin
						case (held_q)
							OPR_ADD: begin
								nx_first  = add_c.val;
								nx_second = '0;
								nx_shown  = add_c.val;
								nx_sat    = add_c.sat;
							end
							OPR_SUB: begin
								nx_first  = sub_c.val;
								nx_second = '0;
								nx_shown  = sub_c.val;
								nx_sat    = sub_c.sat;
							end
							OPR_MUL: begin
								launch = 1'b1;
							end
							default: begin
								if (second_q == '0) begin
									nx_dz      = 1'b1;
									nx_first   = '0;
									nx_second  = '0;
									nx_shown   = '0;
									nx_pressed = 1'b0;
								end else begin
									launch = 1'b1;
								end
							end
						endcase
					end
					if (operation == OP_OPERATOR) begin
						nx_held    = operator_code;
						nx_pressed = 1'b1;
						nx_present = 1'b1;
					end
					if (launch) begin
						commit = 1'b0;
						st_d   = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				if (rsp.done) begin
					st_d = ST_FIN;
				end
			end
			ST_FIN: begin
				commit    = 1'b1;
				nx_first  = fin_c.val;
				nx_second = '0;
				nx_shown  = fin_c.val;
				nx_sat    = fin_c.sat;
				if (pend_q) begin
					nx_held    = code_q;
					nx_pressed = 1'b1;
					nx_present = 1'b1;
				end
				st_d = ST_IDLE;
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
		req.start  = launch;
		req.is_div = (held_q == OPR_DIV);
	end

	// Advance the sequencer and commit the calculator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			first_q     <= '0;
			second_q    <= '0;
			shown_q     <= '0;
			pressed_q   <= 1'b0;
			present_q   <= 1'b0;
			held_q      <= OPR_ADD;
			dz_q        <= 1'b0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			st_q <= st_d;
			if (launch) begin
				pend_q <= (operation == OP_OPERATOR);
			end
			if (commit) begin
				first_q     <= nx_first;
				second_q    <= nx_second;
				shown_q     <= nx_shown;
				pressed_q   <= nx_pressed;
				present_q   <= nx_present;
				held_q      <= nx_held;
				dz_q        <= nx_dz;
				sat_q       <= nx_sat;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the sign and the operator code of a launched multiply or divide
	always_ff @(posedge clk) begin
		if (launch) begin
			neg_q  <= first_q[DATA_W-1] ^ second_q[DATA_W-1];
			code_q <= operator_code;
		end
	end

	assign out_valid       = out_valid_q;
	assign display_value   = shown_q;
	assign first_value     = first_q;
	assign second_value    = second_q;
	assign chosen_operator = held_q;
	assign operator_valid  = present_q;
	assign divide_by_zero  = dz_q;
	assign saturated       = sat_q;

endmodule
`default_nettype wire
